/* src/vdi_pkg.sv */
// Package with the shared constants, types and state encoding of the vertex dedup indexer.
`timescale 1ns / 1ps

package vdi_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int COORD_BITS  = 24;
	localparam int TOL_W       = 23;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int MAG_W       = COORD_BITS + 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t pos_x;
		coord_t pos_y;
		coord_t pos_z;
		coord_t tex_u;
		coord_t tex_v;
		coord_t norm_x;
		coord_t norm_y;
		coord_t norm_z;
	} vertex_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	// True when a and b differ by strictly less than tol.
	function automatic logic coord_close(coord_t a, coord_t b, logic [TOL_W-1:0] tol);
		logic signed [MAG_W-1:0] diff;
		logic [MAG_W-1:0] mag;
		diff = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
		return mag < MAG_W'(tol);
	endfunction

endpackage

/* src/vdi_ifs.sv */
// Handshake interfaces for the vertex, result and configuration channels.
`timescale 1ns / 1ps

interface vdi_vertex_if;
	import vdi_pkg::*;

	logic   valid;
	logic   ready;
	logic   first_of_mesh;
	coord_t pos_x;
	coord_t pos_y;
	coord_t pos_z;
	coord_t tex_u;
	coord_t tex_v;
	coord_t norm_x;
	coord_t norm_y;
	coord_t norm_z;

	modport source (
		output valid, first_of_mesh, pos_x, pos_y, pos_z, tex_u, tex_v,
		       norm_x, norm_y, norm_z,
		input  ready
	);
	modport sink (
		input  valid, first_of_mesh, pos_x, pos_y, pos_z, tex_u, tex_v,
		       norm_x, norm_y, norm_z,
		output ready
	);
endinterface

interface vdi_result_if;
	import vdi_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] vertex_index;
	logic             was_found;
	logic             table_overflow;

	modport source (
		output valid, vertex_index, was_found, table_overflow,
		input  ready
	);
	modport sink (
		input  valid, vertex_index, was_found, table_overflow,
		output ready
	);
endinterface

interface vdi_cfg_if;
	import vdi_pkg::*;

	logic             valid;
	logic             ready;
	logic [TOL_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* src/vertex_dedup_indexer_top.sv */
// Vertex dedup indexer: searches a table of unique vertices and returns a match or a new index.
//
// Each vertex word is compared against the stored unique vertices one entry per clock, in
// insertion order, through a single compare unit fed by the one read port of the vertex table.
// A vertex whose first match is entry i ends its scan at that entry; a vertex that matches nothing
// is compared against every stored entry first, and against none when the table is empty. The
// result passes through a result register and an output register on its way out. The input is
// not ready while a vertex is being searched, and it becomes ready again in the cycle that the
// result appears. A result that the receiver holds back keeps the next vertex's result waiting
// and the input closed after that vertex. The table needs no clearing pass after reset or on
// first_of_mesh: only entries below the fill count are ever read. Tolerance writes are taken at
// any time and should only be made while the block is idle.
`timescale 1ns / 1ps

module vertex_dedup_indexer_top (
	input  logic                clk,
	input  logic                arst_n,
	vdi_cfg_if.sink             cfg,
	vdi_vertex_if.sink          vtx,
	vdi_result_if.source        res
);
	import vdi_pkg::*;

	state_t state_q, state_d;

	logic [TOL_W-1:0] tol_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] addr_q;
	vertex_t          vertex_q;

	vertex_t          mem [TABLE_DEPTH];
	vertex_t          rd_data_s1;
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;

	logic [IDX_W-1:0] rslt_index_q;
	logic             rslt_found_q;
	logic             rslt_ovf_q;

	logic             out_valid_q;
	logic [IDX_W-1:0] out_index_q;
	logic             out_found_q;
	logic             out_ovf_q;

	logic vtx_take;
	logic issue;
	logic hit;
	logic scan_miss;
	logic table_full;
	logic tbl_we;
	logic out_free;

	assign vtx_take   = vtx.valid && vtx.ready;
	assign issue      = (state_q == ST_SCAN) && (addr_q < count_q);
	assign table_full = (count_q == CNT_W'(TABLE_DEPTH));
	assign out_free   = !out_valid_q || res.ready;

	// Shared compare unit: all eight fields of one stored entry per cycle.
	always_comb begin
		hit = valid_s1
			&& coord_close(vertex_q.pos_x,  rd_data_s1.pos_x,  tol_q)
			&& coord_close(vertex_q.pos_y,  rd_data_s1.pos_y,  tol_q)
			&& coord_close(vertex_q.pos_z,  rd_data_s1.pos_z,  tol_q)
			&& coord_close(vertex_q.tex_u,  rd_data_s1.tex_u,  tol_q)
			&& coord_close(vertex_q.tex_v,  rd_data_s1.tex_v,  tol_q)
			&& coord_close(vertex_q.norm_x, rd_data_s1.norm_x, tol_q)
			&& coord_close(vertex_q.norm_y, rd_data_s1.norm_y, tol_q)
			&& coord_close(vertex_q.norm_z, rd_data_s1.norm_z, tol_q);
	end

	// The scan has missed once every entry has been issued and the last one compared.
	assign scan_miss = (state_q == ST_SCAN) && !hit && !issue && !valid_s1;
	assign tbl_we    = scan_miss && !table_full;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (vtx_take) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (hit || scan_miss) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		vtx.ready = (state_q == ST_IDLE);
		cfg.ready = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tol_q       <= TOL_W'(41);
			count_q     <= '0;
			addr_q      <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) tol_q <= cfg.data;
			if (vtx_take) begin
				addr_q <= '0;
				if (vtx.first_of_mesh) count_q <= '0;
			end else if (issue) begin
				addr_q <= addr_q + 1'b1;
			end
			if (tbl_we) count_q <= count_q + 1'b1;
			valid_s1 <= issue && !hit;
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vtx_take) begin
			vertex_q.pos_x  <= vtx.pos_x;
			vertex_q.pos_y  <= vtx.pos_y;
			vertex_q.pos_z  <= vtx.pos_z;
			vertex_q.tex_u  <= vtx.tex_u;
			vertex_q.tex_v  <= vtx.tex_v;
			vertex_q.norm_x <= vtx.norm_x;
			vertex_q.norm_y <= vtx.norm_y;
			vertex_q.norm_z <= vtx.norm_z;
		end
		idx_s1 <= addr_q[IDX_W-1:0];
		if (hit) begin
			rslt_index_q <= idx_s1;
			rslt_found_q <= 1'b1;
			rslt_ovf_q   <= 1'b0;
		end else if (scan_miss) begin
			rslt_index_q <= table_full ? '0 : count_q[IDX_W-1:0];
			rslt_found_q <= 1'b0;
			rslt_ovf_q   <= table_full;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_index_q <= rslt_index_q;
			out_found_q <= rslt_found_q;
			out_ovf_q   <= rslt_ovf_q;
		end
	end

	// Vertex table: one write port for appends, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (tbl_we) mem[count_q[IDX_W-1:0]] <= vertex_q;
		rd_data_s1 <= mem[addr_q[IDX_W-1:0]];
	end

	assign res.valid          = out_valid_q;
	assign res.vertex_index   = out_index_q;
	assign res.was_found      = out_found_q;
	assign res.table_overflow = out_ovf_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_addr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (addr_q <= count_q))
		else $error("scan address ran past the fill count");

	a_compare_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == ST_SCAN))
		else $error("compare stage active outside a scan");

	a_result_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_found_q && out_ovf_q))
		else $error("result both found and overflowed");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(tbl_we && !vtx_take) |=> (count_q == $past(count_q) + 1'b1))
		else $error("append did not advance the fill count");
`endif

endmodule
